>>> src/sbus_pkg.sv
// ----------------------------------------------------------------------------
// sbus_pkg
// Shared constants and types for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbus_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int DATA_BYTES    = FRAME_BYTES - 2;   // bytes 1 .. 23
  localparam int ANALOG_CH     = 16;
  localparam int CH_BITS       = 11;
  localparam int PACKED_BITS   = ANALOG_CH * CH_BITS;
  localparam int NUM_RESULTS   = ANALOG_CH + 2;
  localparam int COUNT_W       = 5;
  localparam int INDEX_W       = 5;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_BYTES - 1);
  localparam logic [COUNT_W-1:0] FLAG_COUNT = COUNT_W'(DATA_BYTES);

  localparam logic [INDEX_W-1:0] IDX_DIG0 = INDEX_W'(ANALOG_CH);
  localparam logic [INDEX_W-1:0] IDX_DIG1 = INDEX_W'(ANALOG_CH + 1);

  localparam int FLAG_DIG0_BIT = 0;
  localparam int FLAG_DIG1_BIT = 1;
  localparam int FLAG_LOST_BIT = 2;
  localparam int FLAG_FS_BIT   = 3;

  localparam logic [7:0] HEADER_RST      = 8'h0f;
  localparam logic [7:0] FOOTER_RST      = 8'h00;
  localparam logic [7:0] FOOTER_MASK_RST = 8'h0f;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER_VALUE = 2'd0,
    CFG_FOOTER_VALUE = 2'd1,
    CFG_FOOTER_MASK  = 2'd2
  } cfg_reg_t;

  typedef logic [7:0] byte_t;

endpackage

>>> src/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Takes one received byte per transaction. Idle until the header byte shows
// up, then collects a 25-byte frame. On the final byte the footer is checked
// (exact match, or match after the footer mask). A good frame is latched into
// an output buffer and played out as 18 result transactions: analog channels
// 0..15, then digital channels 16 and 17, each tagged with the lost-frame and
// failsafe flags; the last one has last_of_frame set. Bad frames vanish.
// Input takes one byte per cycle. Results leave one per cycle from the output
// buffer while out_stall is low. The input side stalls only when a frame's
// final byte arrives while the previous burst is still being played out; with
// a full-rate byte stream and no output stall, the burst ends before the next
// frame's final byte, so the sustained rate is one byte per cycle.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
  import sbus_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_rx_byte,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [INDEX_W-1:0]     out_channel_index,
  output logic [CH_BITS-1:0]     out_channel_value,
  output logic                   out_frame_lost,
  output logic                   out_failsafe_active,
  output logic                   out_last_of_frame
);

  byte_t header_r, footer_r, mask_r;

  logic               in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  byte_t              data_r [DATA_BYTES];

  logic                   busy_r, busy_nxt;
  logic [INDEX_W-1:0]     idx_r, idx_nxt;
  logic [PACKED_BITS-1:0] packed_r;
  byte_t                  flags_r;

  logic in_acc, out_acc, frame_done, footer_ok, load;
  logic [PACKED_BITS-1:0] packed_nxt;
  logic [CH_BITS-1:0] ch [ANALOG_CH];

  assign in_stall   = busy_r && in_frame_r && (count_r == LAST_COUNT);
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign frame_done = in_acc && in_frame_r && (count_r == LAST_COUNT);
  assign footer_ok  = (in_rx_byte == footer_r) || ((in_rx_byte & mask_r) == footer_r);
  assign load       = frame_done && footer_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      footer_r <= FOOTER_RST;
      mask_r   <= FOOTER_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_VALUE: header_r <= cfg_data;
        CFG_FOOTER_VALUE: footer_r <= cfg_data;
        CFG_FOOTER_MASK:  mask_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    if (in_acc) begin
      if (!in_frame_r) begin
        if (in_rx_byte == header_r) begin
          in_frame_nxt = 1'b1;
          count_nxt    = COUNT_W'(1);
        end
      end else if (count_r == LAST_COUNT) begin
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
      end else begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_frame_r && (count_r != LAST_COUNT)) begin
      data_r[count_r - COUNT_W'(1)] <= in_rx_byte;
    end
  end

  // channel bits are packed LSB first starting at byte 1
  always_comb begin
    for (int i = 0; i < ANALOG_CH * CH_BITS / 8; i++) begin
      packed_nxt[i*8 +: 8] = data_r[i];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_acc) begin
      if (idx_r == IDX_DIG1) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packed_r <= packed_nxt;
      flags_r  <= data_r[FLAG_COUNT - COUNT_W'(1)];
    end
  end

  always_comb begin
    for (int k = 0; k < ANALOG_CH; k++) begin
      ch[k] = packed_r[k*CH_BITS +: CH_BITS];
    end
  end

  always_comb begin
    case (idx_r)
      IDX_DIG0: out_channel_value = CH_BITS'(flags_r[FLAG_DIG0_BIT]);
      IDX_DIG1: out_channel_value = CH_BITS'(flags_r[FLAG_DIG1_BIT]);
      default:  out_channel_value = ch[idx_r[$clog2(ANALOG_CH)-1:0]];
    endcase
  end

  assign out_valid           = busy_r;
  assign out_channel_index   = idx_r;
  assign out_frame_lost      = flags_r[FLAG_LOST_BIT];
  assign out_failsafe_active = flags_r[FLAG_FS_BIT];
  assign out_last_of_frame   = (idx_r == IDX_DIG1);

endmodule

>>> src/sbus_chk.sv
// ----------------------------------------------------------------------------
// sbus_chk
// Port-level checks for the SBUS frame decoder result channel.
// ----------------------------------------------------------------------------
module sbus_chk
  import sbus_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [INDEX_W-1:0]     out_channel_index,
  input logic [CH_BITS-1:0]     out_channel_value,
  input logic                   out_frame_lost,
  input logic                   out_failsafe_active,
  input logic                   out_last_of_frame
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid
      && $stable(out_channel_index) && $stable(out_channel_value))
    else $error("stalled result changed");

  // burst continues with the next channel until the last one
  a_burst_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_frame |=>
      out_valid && (out_channel_index == $past(out_channel_index) + INDEX_W'(1))
      && $stable(out_frame_lost) && $stable(out_failsafe_active))
    else $error("burst sequence broken");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_frame == (out_channel_index == IDX_DIG1)))
    else $error("last_of_frame mismatch");

  a_digital: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_channel_index == IDX_DIG0 || out_channel_index == IDX_DIG1)
      |-> out_channel_value <= CH_BITS'(1))
    else $error("digital channel not 0/1");

endmodule

bind sbus_frame_decoder sbus_chk u_sbus_chk (.*);
